// ===== rtl/core/segment_lcd_number_formatter_assert.svh =====
// Assertion macros for the segment LCD formatter.
`ifndef SEGMENT_LCD_NUMBER_FORMATTER_ASSERT_SVH
`define SEGMENT_LCD_NUMBER_FORMATTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLFMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLFMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/slfmt_pkg.sv =====
`default_nettype none

package slfmt_pkg;

  typedef enum logic [2:0] {
    OP_BIG    = 3'd0,
    OP_SMALL  = 3'd1,
    OP_TEMP   = 3'd2,
    OP_SMILEY = 3'd3,
    OP_LINK   = 3'd4,
    OP_BATT   = 3'd5,
    OP_CLOCK  = 3'd6
  } op_e;

  localparam logic signed [15:0] BIG_HI_LIMIT = 16'sd19995;
  localparam logic signed [15:0] BIG_LO_LIMIT = -16'sd995;
  localparam logic signed [15:0] BIG_POINT_HI = 16'sd1995;
  localparam logic signed [15:0] BIG_POINT_LO = -16'sd95;
  localparam logic signed [15:0] SMALL_HI     = 16'sd99;
  localparam logic signed [15:0] SMALL_LO     = -16'sd9;

  localparam logic [7:0] SYM_H        = 8'h67;
  localparam logic [7:0] SYM_I        = 8'h04;
  localparam logic [7:0] SYM_L        = 8'h85;
  localparam logic [7:0] SYM_O        = 8'hC6;
  localparam logic [7:0] BIG_MINUS    = 8'h02;
  localparam logic [7:0] BIG_POINT    = 8'h08;
  localparam logic [7:0] BIG_THOUSAND = 8'h08;
  localparam logic [7:0] SMALL_H      = 8'h76;
  localparam logic [7:0] SMALL_I      = 8'h10;
  localparam logic [7:0] SMALL_L      = 8'h51;
  localparam logic [7:0] SMALL_O      = 8'h33;
  localparam logic [7:0] SMALL_MINUS  = 8'h20;
  localparam logic [7:0] MARK_BIT     = 8'h80;

  // Reciprocal multipliers for division by constants.
  localparam logic [15:0] DIV10_MAGIC  = 16'hCCCD;   // >> 19, 16-bit dividend
  localparam logic [12:0] DIV100_MAGIC = 13'd5243;   // >> 19, 11-bit dividend
  localparam logic [31:0] DIV60_MAGIC  = 32'h88888889; // >> 37, 32-bit dividend
  localparam logic [31:0] DIV24_MAGIC  = 32'hAAAAAAAB; // >> 36, 32-bit dividend
  localparam logic [7:0]  SMALL_DIV10  = 8'd205;     // >> 11, 7-bit dividend

  typedef struct packed {
    op_e                op;
    logic signed [15:0] number;
    logic [7:0]         code;
    logic               percent;
  } ctl_t;

  typedef struct packed {
    logic        hi;
    logic        lo;
    logic        point;
    logic        neg;
    logic [10:0] w;
    logic [7:0]  d10;
    logic [4:0]  d100;
  } big_t;

  typedef struct packed {
    logic [20:0] hrs_all;
    logic [5:0]  mins;
    logic [52:0] p3;
  } time_t;

  function automatic logic [7:0] big_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hF5;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hB6;
      4'd3:    s = 8'hF2;
      4'd4:    s = 8'h63;
      4'd5:    s = 8'hD3;
      4'd6:    s = 8'hD7;
      4'd7:    s = 8'h70;
      4'd8:    s = 8'hF7;
      4'd9:    s = 8'hF3;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] small_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h5F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h3D;
      4'd3:    s = 8'h2F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6B;
      4'd6:    s = 8'h7B;
      4'd7:    s = 8'h0E;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slfmt_big.sv =====
`default_nettype none

module slfmt_big (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] number_i,
  output slfmt_pkg::big_t         big_o
);

  logic        hi_a_q, lo_a_q, pt_a_q, neg_a_q;
  logic [15:0] v_a_q;
  logic [31:0] qv_a_q;
  logic        hi_b_q, lo_b_q, pt_b_q, neg_b_q;
  logic [10:0] w_b_q;
  slfmt_pkg::big_t big_q;

  logic        neg_d;
  logic [15:0] v_d;
  logic [31:0] qv_d;
  logic [12:0] q_b;
  logic [15:0] r_b;
  logic [15:0] w_full;
  logic [26:0] p10_c;
  logic [23:0] p100_c;

  // Stage A: range classes, magnitude and its tenths quotient product.
  always_comb begin
    neg_d = number_i[15];
    v_d   = neg_d ? 16'(-number_i) : 16'(number_i);
    qv_d  = 32'(v_d) * 32'(slfmt_pkg::DIV10_MAGIC);
  end

  // Stage B: whole-number rounding goes up only on a remainder of six or more.
  always_comb begin
    q_b    = qv_a_q[31:19];
    r_b    = v_a_q - 16'(q_b) * 16'd10;
    w_full = pt_a_q ? v_a_q : 16'(q_b) + 16'(r_b[3:0] > 4'd5);
  end

  // Stage C: tens and hundreds quotients of the shown value.
  always_comb begin
    p10_c  = 27'(w_b_q) * 27'(slfmt_pkg::DIV10_MAGIC);
    p100_c = 24'(w_b_q) * 24'(slfmt_pkg::DIV100_MAGIC);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_a_q  <= number_i > slfmt_pkg::BIG_HI_LIMIT;
      lo_a_q  <= number_i < slfmt_pkg::BIG_LO_LIMIT;
      pt_a_q  <= (number_i <= slfmt_pkg::BIG_POINT_HI) &&
                 (number_i >= slfmt_pkg::BIG_POINT_LO);
      neg_a_q <= neg_d;
      v_a_q   <= v_d;
      qv_a_q  <= qv_d;

      hi_b_q  <= hi_a_q;
      lo_b_q  <= lo_a_q;
      pt_b_q  <= pt_a_q;
      neg_b_q <= neg_a_q;
      w_b_q   <= w_full[10:0];

      big_q.hi    <= hi_b_q;
      big_q.lo    <= lo_b_q;
      big_q.point <= pt_b_q;
      big_q.neg   <= neg_b_q;
      big_q.w     <= w_b_q;
      big_q.d10   <= p10_c[26:19];
      big_q.d100  <= p100_c[23:19];
    end
  end

  assign big_o = big_q;

endmodule

`default_nettype wire

// ===== rtl/core/slfmt_clock.sv =====
`default_nettype none

module slfmt_clock (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] seconds_i,
  output slfmt_pkg::time_t time_o
);

  logic [63:0] p1_a_q;
  logic [26:0] t_b_q;
  logic [58:0] p2_b_q;
  slfmt_pkg::time_t time_q;

  logic [63:0] p1_d;
  logic [26:0] t_d;
  logic [58:0] p2_d;
  logic [20:0] h_c;
  logic [26:0] m_c;
  logic [52:0] p3_c;

  always_comb begin
    p1_d = 64'(seconds_i) * 64'(slfmt_pkg::DIV60_MAGIC);
    // Minutes since the count started, then its hours product.
    t_d  = p1_a_q[63:37];
    p2_d = 59'(t_d) * 59'(slfmt_pkg::DIV60_MAGIC);
    h_c  = p2_b_q[57:37];
    m_c  = t_b_q - 27'(h_c) * 27'd60;
    p3_c = 53'(h_c) * 53'(slfmt_pkg::DIV24_MAGIC);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_a_q         <= p1_d;
      t_b_q          <= t_d;
      p2_b_q         <= p2_d;
      time_q.hrs_all <= h_c;
      time_q.mins    <= m_c[5:0];
      time_q.p3      <= p3_c;
    end
  end

  assign time_o = time_q;

endmodule

`default_nettype wire

// ===== rtl/core/slfmt_image.sv =====
`default_nettype none

module slfmt_image (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire slfmt_pkg::ctl_t  ctl_i,
  input  wire slfmt_pkg::big_t  big_i,
  input  wire slfmt_pkg::time_t time_i,
  output logic [5:0][7:0]       img_o,
  output logic                  out_valid_o
);

  logic [5:0][7:0] img_q, img_d;
  logic            out_valid_q;
  logic            upd;

  logic [10:0] b_ones_w;
  logic [7:0]  b_tens_w;
  logic [3:0]  b_ones, b_tens, b_hund;
  logic [4:0]  b_hund_w;

  logic        s_neg;
  logic [15:0] s_mag;
  logic [6:0]  s_v;
  logic [14:0] s_tens_p;
  logic [3:0]  s_tens;
  logic [6:0]  s_ones_w;

  logic [16:0] c_q24;
  logic [20:0] c_hr_w;
  logic [4:0]  c_hr;
  logic [1:0]  c_htens;
  logic [4:0]  c_hones_w;
  logic [2:0]  c_mtens;
  logic [5:0]  c_mones_w;

  assign upd = en_i && valid_i;

  // Digit extraction for the three formats.
  always_comb begin
    b_ones_w = big_i.w - 11'(big_i.d10) * 11'd10;
    b_tens_w = big_i.d10 - 8'(big_i.d100) * 8'd10;
    b_hund_w = (big_i.d100 >= 5'd10) ? big_i.d100 - 5'd10 : big_i.d100;
    b_ones   = b_ones_w[3:0];
    b_tens   = b_tens_w[3:0];
    b_hund   = b_hund_w[3:0];

    s_neg    = ctl_i.number[15];
    s_mag    = s_neg ? -ctl_i.number : ctl_i.number;
    s_v      = s_mag[6:0];
    s_tens_p = 15'(s_v) * 15'(slfmt_pkg::SMALL_DIV10);
    s_tens   = s_tens_p[14:11];
    s_ones_w = s_v - 7'(s_tens) * 7'd10;

    c_q24     = time_i.p3[52:36];
    c_hr_w    = time_i.hrs_all - 21'(c_q24) * 21'd24;
    c_hr      = c_hr_w[4:0];
    c_htens   = (c_hr >= 5'd20) ? 2'd2 : (c_hr >= 5'd10) ? 2'd1 : 2'd0;
    c_hones_w = c_hr - 5'(c_htens) * 5'd10;
    c_mtens   = (time_i.mins >= 6'd50) ? 3'd5 :
                (time_i.mins >= 6'd40) ? 3'd4 :
                (time_i.mins >= 6'd30) ? 3'd3 :
                (time_i.mins >= 6'd20) ? 3'd2 :
                (time_i.mins >= 6'd10) ? 3'd1 : 3'd0;
    c_mones_w = time_i.mins - 6'(c_mtens) * 6'd10;
  end

  always_comb begin
    img_d = img_q;
    case (ctl_i.op)
      slfmt_pkg::OP_BIG: begin
        img_d[1] = 8'h00;
        img_d[2] = 8'h00;
        if (big_i.hi) begin
          img_d[0] = slfmt_pkg::SYM_H;
          img_d[1] = slfmt_pkg::SYM_I;
        end else if (big_i.lo) begin
          img_d[0] = slfmt_pkg::SYM_L;
          img_d[1] = slfmt_pkg::SYM_O;
        end else begin
          img_d[0] = big_i.neg ? slfmt_pkg::BIG_MINUS : 8'h00;
          if (big_i.point) begin
            img_d[2] = slfmt_pkg::BIG_POINT;
          end
          if (big_i.w > 11'd999) begin
            img_d[0] = img_d[0] | slfmt_pkg::BIG_THOUSAND;
          end
          if (big_i.w > 11'd99) begin
            img_d[0] = img_d[0] | slfmt_pkg::big_seg(b_hund);
          end
          // Below ten the tens digit is zero, which is what is shown.
          img_d[1] = img_d[1] | slfmt_pkg::big_seg(b_tens);
          img_d[2] = img_d[2] | slfmt_pkg::big_seg(b_ones);
        end
      end
      slfmt_pkg::OP_SMALL: begin
        img_d[4]    = 8'h00;
        img_d[5]    = 8'h00;
        img_d[3][4] = ctl_i.percent;
        if (ctl_i.number > slfmt_pkg::SMALL_HI) begin
          img_d[5] = slfmt_pkg::SMALL_H;
          img_d[4] = slfmt_pkg::SMALL_I;
        end else if (ctl_i.number < slfmt_pkg::SMALL_LO) begin
          img_d[5] = slfmt_pkg::SMALL_L;
          img_d[4] = slfmt_pkg::SMALL_O;
        end else begin
          if (s_neg) begin
            img_d[5] = slfmt_pkg::SMALL_MINUS;
          end
          if (s_v > 7'd9) begin
            img_d[5] = img_d[5] | slfmt_pkg::small_seg(s_tens);
          end
          img_d[4] = slfmt_pkg::small_seg(s_ones_w[3:0]);
        end
      end
      slfmt_pkg::OP_TEMP: begin
        img_d[3][0] = ctl_i.code[5];
        img_d[3][1] = ctl_i.code[6];
        img_d[3][2] = ctl_i.code[7];
      end
      slfmt_pkg::OP_SMILEY: begin
        img_d[1][3] = ctl_i.code[2];
        img_d[3][6] = ctl_i.code[0];
        img_d[3][5] = ctl_i.code[1];
      end
      slfmt_pkg::OP_LINK: begin
        img_d[4][7] = |ctl_i.code;
      end
      slfmt_pkg::OP_BATT: begin
        img_d[5][7] = |ctl_i.code;
      end
      slfmt_pkg::OP_CLOCK: begin
        img_d[0] = slfmt_pkg::big_seg(c_hones_w[3:0]);
        img_d[1] = slfmt_pkg::big_seg({2'b00, c_htens});
        img_d[2] = 8'h00;
        img_d[3] = 8'h00;
        // The link and battery marks survive a clock update.
        img_d[4] = (img_q[4] & slfmt_pkg::MARK_BIT) | slfmt_pkg::small_seg({1'b0, c_mtens});
        img_d[5] = (img_q[5] & slfmt_pkg::MARK_BIT) | slfmt_pkg::small_seg(c_mones_w[3:0]);
      end
      default: begin
        img_d = img_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= valid_i;
      if (valid_i) begin
        img_q <= img_d;
      end
    end
  end

  assign img_o       = img_q;
  assign out_valid_o = out_valid_q;

`include "segment_lcd_number_formatter_assert.svh"

  `SLFMT_ASSERT_NXT(a_img_hold, clk_i, rst_ni, !upd, $stable(img_q),
                    "image changed with no word retiring")
  `SLFMT_ASSERT_IMP(a_big_range, clk_i, rst_ni,
                    upd && ctl_i.op == slfmt_pkg::OP_BIG && !big_i.hi && !big_i.lo,
                    big_i.w <= 11'd1999 && b_ones_w <= 11'd9 && b_tens_w <= 8'd9,
                    "big number digit out of range")
  `SLFMT_ASSERT_IMP(a_clock_range, clk_i, rst_ni,
                    upd && ctl_i.op == slfmt_pkg::OP_CLOCK,
                    c_hr <= 5'd23 && time_i.mins <= 6'd59,
                    "clock hours or minutes out of range")

endmodule

`default_nettype wire

// ===== rtl/core/segment_lcd_number_formatter.sv =====
// Segment LCD number formatter: one command word in, the whole six-byte image out.
// The image for a word is built through the input register, stages A, B and C and the image register.
// Throughput: one word per cycle; all stages advance together and hold while the
// output word waits. The clock's three reciprocal multiplies, one per stage, set the depth.
// Reset clears the segment image to all zero and empties the pipeline.
`default_nettype none

module segment_lcd_number_formatter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         op_i,
  input  wire logic signed [15:0] number_i,
  input  wire logic [7:0]         code_i,
  input  wire logic               percent_i,
  input  wire logic [31:0]        seconds_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              seg_byte0_o,
  output logic [7:0]              seg_byte1_o,
  output logic [7:0]              seg_byte2_o,
  output logic [7:0]              seg_byte3_o,
  output logic [7:0]              seg_byte4_o,
  output logic [7:0]              seg_byte5_o
);

  logic            en;
  logic            v0_q, va_q, vb_q, vc_q;
  slfmt_pkg::ctl_t ctl0_q, ctla_q, ctlb_q, ctlc_q, ctl0_d;
  logic [31:0]     secs0_q;
  slfmt_pkg::big_t  big_c;
  slfmt_pkg::time_t time_c;
  logic [5:0][7:0] img;
  logic            out_valid;

  // The pipeline moves only when the output word is free or being taken.
  assign en         = !out_valid || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    ctl0_d.op      = slfmt_pkg::op_e'(op_i);
    ctl0_d.number  = number_i;
    ctl0_d.code    = code_i;
    ctl0_d.percent = percent_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      va_q <= v0_q;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (in_valid_i) begin
        ctl0_q  <= ctl0_d;
        secs0_q <= seconds_i;
      end
      ctla_q <= ctl0_q;
      ctlb_q <= ctla_q;
      ctlc_q <= ctlb_q;
    end
  end

  slfmt_big u_big (
    .clk_i    (clk_i),
    .en_i     (en),
    .number_i (ctl0_q.number),
    .big_o    (big_c)
  );

  slfmt_clock u_clock (
    .clk_i     (clk_i),
    .en_i      (en),
    .seconds_i (secs0_q),
    .time_o    (time_c)
  );

  slfmt_image u_image (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (vc_q),
    .ctl_i       (ctlc_q),
    .big_i       (big_c),
    .time_i      (time_c),
    .img_o       (img),
    .out_valid_o (out_valid)
  );

  assign out_valid_o = out_valid;
  assign seg_byte0_o = img[0];
  assign seg_byte1_o = img[1];
  assign seg_byte2_o = img[2];
  assign seg_byte3_o = img[3];
  assign seg_byte4_o = img[4];
  assign seg_byte5_o = img[5];

endmodule

`default_nettype wire

// ===== tb/sv/segment_lcd_number_formatter_tb.sv =====
`timescale 1ns / 100ps

module segment_lcd_number_formatter_tb;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int ITEMS_PER_PHASE = 450;
  localparam int HOLD_CYCLES = 240;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;

  // Display limits and glyphs, kept independent of the design's package.
  localparam int TENTHS_HI = 19995;
  localparam int TENTHS_LO = -995;
  localparam int POINT_HI = 1995;
  localparam int POINT_LO = -95;
  localparam logic [7:0] GLYPH_BIG_H = 8'h67;
  localparam logic [7:0] GLYPH_BIG_I = 8'h04;
  localparam logic [7:0] GLYPH_BIG_L = 8'h85;
  localparam logic [7:0] GLYPH_BIG_O = 8'hC6;
  localparam logic [7:0] GLYPH_BIG_MINUS = 8'h02;
  localparam logic [7:0] GLYPH_BIG_POINT = 8'h08;
  localparam logic [7:0] GLYPH_THOUSAND = 8'h08;
  localparam logic [7:0] GLYPH_SMALL_H = 8'h76;
  localparam logic [7:0] GLYPH_SMALL_I = 8'h10;
  localparam logic [7:0] GLYPH_SMALL_L = 8'h51;
  localparam logic [7:0] GLYPH_SMALL_O = 8'h33;
  localparam logic [7:0] GLYPH_SMALL_MINUS = 8'h20;
  localparam logic [7:0] BIG_GLYPH [0:9] = '{
    8'hF5, 8'h60, 8'hB6, 8'hF2, 8'h63, 8'hD3, 8'hD7, 8'h70, 8'hF7, 8'hF3
  };
  localparam logic [7:0] SMALL_GLYPH [0:9] = '{
    8'h5F, 8'h06, 8'h3D, 8'h2F, 8'h66, 8'h6B, 8'h7B, 8'h0E, 8'h7F, 8'h6F
  };

  typedef logic [5:0][7:0] image_t;

  class image_scoreboard;
    image_t image;
    image_t expected_images[$];
    int mismatches;
    int words_checked;
    int op_count [0:7];

    function new();
      image = '0;
      mismatches = 0;
      words_checked = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function void show_big(input int n);
      int unsigned mag;
      image[1] = '0;
      image[2] = '0;
      if (n > TENTHS_HI) begin
        image[0] = GLYPH_BIG_H;
        image[1] = GLYPH_BIG_I;
      end else if (n < TENTHS_LO) begin
        image[0] = GLYPH_BIG_L;
        image[1] = GLYPH_BIG_O;
      end else begin
        image[0] = (n < 0) ? GLYPH_BIG_MINUS : 8'h00;
        mag = (n < 0) ? -n : n;
        // Whole numbers round up only on a remainder of six or more.
        if (n > POINT_HI || n < POINT_LO) begin
          mag = mag / 10 + ((mag % 10 > 5) ? 1 : 0);
        end else begin
          image[2] = GLYPH_BIG_POINT;
        end
        if (mag > 999) image[0] |= GLYPH_THOUSAND;
        if (mag > 99) image[0] |= BIG_GLYPH[(mag / 100) % 10];
        image[1] |= BIG_GLYPH[(mag > 9) ? (mag / 10) % 10 : 0];
        image[2] |= BIG_GLYPH[mag % 10];
      end
    endfunction

    function void show_small(input int n, input logic pct);
      int unsigned mag;
      image[4] = '0;
      image[5] = '0;
      image[3][4] = pct;
      if (n > 99) begin
        image[5] = GLYPH_SMALL_H;
        image[4] = GLYPH_SMALL_I;
      end else if (n < -9) begin
        image[5] = GLYPH_SMALL_L;
        image[4] = GLYPH_SMALL_O;
      end else begin
        if (n < 0) image[5] = GLYPH_SMALL_MINUS;
        mag = (n < 0) ? -n : n;
        if (mag > 9) image[5] |= SMALL_GLYPH[(mag / 10) % 10];
        image[4] |= SMALL_GLYPH[mag % 10];
      end
    endfunction

    function void fill_clock_digits(input logic [31:0] seconds);
      logic [31:0] total_mins;
      logic [31:0] mins;
      logic [31:0] hrs;
      total_mins = seconds / 60;
      mins = total_mins % 60;
      hrs = (total_mins / 60) % 24;
      image[0] = BIG_GLYPH[hrs % 10];
      image[1] = BIG_GLYPH[hrs / 10];
      image[2] = '0;
      image[3] = '0;
      // The link and battery marks in bit 7 survive a clock update.
      image[4] = {image[4][7], 7'b0} | SMALL_GLYPH[mins / 10];
      image[5] = {image[5][7], 7'b0} | SMALL_GLYPH[mins % 10];
    endfunction

    function void note_command(input logic [2:0] op, input logic signed [15:0] number,
                               input logic [7:0] code, input logic pct,
                               input logic [31:0] seconds);
      op_count[op]++;
      case (op)
        slfmt_pkg::OP_BIG:   show_big(number);
        slfmt_pkg::OP_SMALL: show_small(number, pct);
        slfmt_pkg::OP_TEMP:  image[3][2:0] = {code[7], code[6], code[5]};
        slfmt_pkg::OP_SMILEY: begin
          image[1][3] = code[2];
          image[3][6] = code[0];
          image[3][5] = code[1];
        end
        slfmt_pkg::OP_LINK:  image[4][7] = (code != 8'h00);
        slfmt_pkg::OP_BATT:  image[5][7] = (code != 8'h00);
        slfmt_pkg::OP_CLOCK: fill_clock_digits(seconds);
        default: ;
      endcase
      expected_images.push_back(image);
    endfunction

    function void check_image(input image_t got);
      image_t want;
      if (expected_images.size() == 0) begin
        $error("image word arrived with none expected: %h", got);
        mismatches++;
      end else begin
        want = expected_images.pop_front();
        words_checked++;
        for (int i = 0; i < 6; i++) begin
          if (got[i] !== want[i]) begin
            $error("seg_byte%0d: expected 0x%02h, actual 0x%02h", i, want[i], got[i]);
            mismatches++;
          end
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] op_i = slfmt_pkg::OP_BIG;
  logic signed [15:0] number_i = '0;
  logic [7:0] code_i = '0;
  logic percent_i = 1'b0;
  logic [31:0] seconds_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] seg_byte0_o;
  logic [7:0] seg_byte1_o;
  logic [7:0] seg_byte2_o;
  logic [7:0] seg_byte3_o;
  logic [7:0] seg_byte4_o;
  logic [7:0] seg_byte5_o;

  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  image_scoreboard sb = new();

  segment_lcd_number_formatter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .number_i    (number_i),
    .code_i      (code_i),
    .percent_i   (percent_i),
    .seconds_i   (seconds_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .seg_byte0_o (seg_byte0_o),
    .seg_byte1_o (seg_byte1_o),
    .seg_byte2_o (seg_byte2_o),
    .seg_byte3_o (seg_byte3_o),
    .seg_byte4_o (seg_byte4_o),
    .seg_byte5_o (seg_byte5_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("segment_lcd_number_formatter test failed");
      $finish;
    end
  end

  // Accepted command words feed the predictor before the result check so that
  // the order is right even if a result could follow in the same cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_command(op_i, number_i, code_i, percent_i, seconds_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_image({seg_byte5_o, seg_byte4_o, seg_byte3_o,
                        seg_byte2_o, seg_byte1_o, seg_byte0_o});
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the toggle changes.
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(input logic [2:0] op, input logic signed [15:0] number,
                           input logic [7:0] code, input logic pct,
                           input logic [31:0] seconds);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    number_i <= number;
    code_i <= code;
    percent_i <= pct;
    seconds_i <= seconds;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random_word();
    logic [2:0] op;
    logic signed [15:0] number;
    logic [7:0] code;
    logic [31:0] seconds;
    op = ($urandom_range(99) < 3) ? OP_UNUSED : 3'($urandom_range(slfmt_pkg::OP_CLOCK));
    case ($urandom_range(3))
      0: number = 16'($urandom());
      1: number = 16'(int'($urandom_range(2400)) - 200);
      2: number = 16'(int'($urandom_range(21200)) - 1100);
      default: number = 16'(int'($urandom_range(130)) - 20);
    endcase
    code = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom());
    seconds = $urandom_range(1) ? $urandom() : $urandom_range(86400 * 2);
    send_word(op, number, code, 1'($urandom()), seconds);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: range limits, rounding, every command and the unused op.
    send_word(slfmt_pkg::OP_SMILEY, '0, 8'h07, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, 16'sd0, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, 16'sd19995, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, 16'sd19996, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, -16'sd995, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, -16'sd996, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, 16'sd1995, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, 16'sd1996, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, -16'sd95, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, -16'sd96, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, 16'sd32767, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, 16'sh8000, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, 16'sd9999, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_BIG, 16'sd1005, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_SMALL, 16'sd99, '0, 1'b1, '0);
    send_word(slfmt_pkg::OP_SMALL, 16'sd100, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_SMALL, -16'sd9, '0, 1'b0, '0);
    send_word(slfmt_pkg::OP_SMALL, -16'sd10, '0, 1'b1, '0);
    send_word(slfmt_pkg::OP_TEMP, '0, 8'hE0, 1'b0, '0);
    send_word(slfmt_pkg::OP_SMILEY, '0, 8'hF8, 1'b0, '0);
    send_word(slfmt_pkg::OP_LINK, '0, 8'h01, 1'b0, '0);
    send_word(slfmt_pkg::OP_BATT, '0, 8'h80, 1'b0, '0);
    send_word(slfmt_pkg::OP_CLOCK, '0, '0, 1'b0, 32'hFFFF_FFFF);
    send_word(slfmt_pkg::OP_CLOCK, '0, '0, 1'b0, 32'd86399);
    send_word(OP_UNUSED, 16'sh7FFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 54; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 54; end
        default: begin send_idle_pct = 24; stall_pct <= 24; end
      endcase
      // Hold the output back for a long while so the pipeline fills and
      // the input has to stall.
      if (phase == 0 || phase == 2) hold_toggle <= ~hold_toggle;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_word();
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (sb.expected_images.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d image words: big %0d, small %0d, temp %0d, smiley %0d,",
             sb.words_checked, sb.op_count[slfmt_pkg::OP_BIG],
             sb.op_count[slfmt_pkg::OP_SMALL], sb.op_count[slfmt_pkg::OP_TEMP],
             sb.op_count[slfmt_pkg::OP_SMILEY]);
    $display("link %0d, battery %0d, clock %0d, unused op %0d, over four handshake mixes.",
             sb.op_count[slfmt_pkg::OP_LINK], sb.op_count[slfmt_pkg::OP_BATT],
             sb.op_count[slfmt_pkg::OP_CLOCK], sb.op_count[OP_UNUSED]);
    if (sb.mismatches == 0) begin
      $display("segment_lcd_number_formatter test passed");
    end else begin
      $display("segment_lcd_number_formatter test failed");
    end
    $finish;
  end

endmodule

// ===== segment_lcd_number_formatter.f =====
+incdir+rtl/core
rtl/core/slfmt_pkg.sv
rtl/core/slfmt_big.sv
rtl/core/slfmt_clock.sv
rtl/core/slfmt_image.sv
rtl/core/segment_lcd_number_formatter.sv
tb/sv/segment_lcd_number_formatter_tb.sv
